// File: src/apc_pkg.sv
`timescale 1ns / 1ps

package apc_pkg;

   // Build-time defaults
   localparam int CODE_LENGTH_DEF = 4;
   localparam int BLINK_HALF_DEF  = 500;

   // Field widths
   localparam int LIGHT_W   = 12;
   localparam int TIMER_W   = 16;
   localparam int DEBOUNCE_W = 8;
   localparam int CODE_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int BLINK_W   = 9;
   localparam int ENTRY_W   = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CODE_PATTERN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_TIMEOUT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE_TICKS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_DELAY      = 3'd4;

   // Register reset values
   localparam logic [CODE_W-1:0]     CODE_PATTERN_RST    = 4'hF;
   localparam logic [LIGHT_W-1:0]    LIGHT_THRESHOLD_RST = 12'd100;
   localparam logic [TIMER_W-1:0]    ENTRY_TIMEOUT_RST   = 16'd5000;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST  = 8'd50;
   localparam logic [TIMER_W-1:0]    EXIT_DELAY_RST      = 16'd3000;

   // Panel modes
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_ARMED = 2'd1,
      MODE_TRIG  = 2'd2
   } mode_type;

   // Code events
   localparam logic [1:0] CODE_EV_NONE  = 2'd0;
   localparam logic [1:0] CODE_EV_WRONG = 2'd1;
   localparam logic [1:0] CODE_EV_RIGHT = 2'd2;

   // Alarm events
   localparam logic [2:0] ALARM_EV_NONE    = 3'd0;
   localparam logic [2:0] ALARM_EV_UNARMED = 3'd1;
   localparam logic [2:0] ALARM_EV_ARMED   = 3'd2;
   localparam logic [2:0] ALARM_EV_MOTION  = 3'd3;
   localparam logic [2:0] ALARM_EV_LIGHT   = 3'd4;

   typedef struct packed {
      logic [CODE_W-1:0]     code_pattern;
      logic [LIGHT_W-1:0]    light_threshold;
      logic [TIMER_W-1:0]    entry_timeout;
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [TIMER_W-1:0]    exit_delay;
   } cfg_type;

   typedef struct packed {
      logic               press_one;
      logic               press_two;
      logic [LIGHT_W-1:0] light_level;
      logic               motion_seen;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         panel_mode;
      logic [1:0]         code_event;
      logic [2:0]         alarm_event;
      logic [ENTRY_W-1:0] code_progress;
      logic               yellow_lamp;
      logic               green_lamp;
      logic               red_lamp;
      logic               buzzer_on;
   } rsp_item_type;

endpackage

// File: src/apc_req_if.sv
`timescale 1ns / 1ps

interface apc_req_if;
   import apc_pkg::*;

   logic               valid;
   logic               ready;
   logic               press_one;
   logic               press_two;
   logic [LIGHT_W-1:0] light_level;
   logic               motion_seen;

   modport source (output valid, press_one, press_two, light_level, motion_seen,
                   input ready);
   modport sink   (input valid, press_one, press_two, light_level, motion_seen,
                   output ready);
endinterface

// File: src/apc_rsp_if.sv
`timescale 1ns / 1ps

interface apc_rsp_if;
   import apc_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         panel_mode;
   logic [1:0]         code_event;
   logic [2:0]         alarm_event;
   logic [ENTRY_W-1:0] code_progress;
   logic               yellow_lamp;
   logic               green_lamp;
   logic               red_lamp;
   logic               buzzer_on;

   modport source (output valid, panel_mode, code_event, alarm_event, code_progress,
                          yellow_lamp, green_lamp, red_lamp, buzzer_on,
                   input ready);
   modport sink   (input valid, panel_mode, code_event, alarm_event, code_progress,
                         yellow_lamp, green_lamp, red_lamp, buzzer_on,
                   output ready);
endinterface

// File: src/apc_csr_if.sv
`timescale 1ns / 1ps

interface apc_csr_if;
   import apc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/apc_csr.sv
`timescale 1ns / 1ps

module apc_csr (
   input  logic             clock,
   input  logic             reset,
   apc_csr_if.sink          csr_chan,
   output apc_pkg::cfg_type cfg
);
   import apc_pkg::*;

   cfg_type cfg_ff;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // Register file; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_pattern    <= CODE_PATTERN_RST;
         cfg_ff.light_threshold <= LIGHT_THRESHOLD_RST;
         cfg_ff.entry_timeout   <= ENTRY_TIMEOUT_RST;
         cfg_ff.debounce_ticks  <= DEBOUNCE_TICKS_RST;
         cfg_ff.exit_delay      <= EXIT_DELAY_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_CODE_PATTERN:    cfg_ff.code_pattern    <= csr_chan.data[CODE_W-1:0];
            REG_LIGHT_THRESHOLD: cfg_ff.light_threshold <= csr_chan.data[LIGHT_W-1:0];
            REG_ENTRY_TIMEOUT:   cfg_ff.entry_timeout   <= csr_chan.data[TIMER_W-1:0];
            REG_DEBOUNCE_TICKS:  cfg_ff.debounce_ticks  <= csr_chan.data[DEBOUNCE_W-1:0];
            REG_EXIT_DELAY:      cfg_ff.exit_delay      <= csr_chan.data[TIMER_W-1:0];
            default: ;
         endcase
      end
   end
endmodule

// File: src/apc_engine.sv
`timescale 1ns / 1ps

module apc_engine #(
   parameter int CODE_LENGTH = apc_pkg::CODE_LENGTH_DEF,
   parameter int BLINK_HALF  = apc_pkg::BLINK_HALF_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  apc_pkg::req_item_type item,
   input  apc_pkg::cfg_type      cfg,
   output apc_pkg::rsp_item_type result
);
   import apc_pkg::*;

   localparam logic [ENTRY_W:0] CODE_LEN_W  = (ENTRY_W+1)'(CODE_LENGTH);
   localparam logic [BLINK_W:0] BLINK_HALF_W = (BLINK_W+1)'(BLINK_HALF);

   mode_type             mode_ff, mode_in;
   logic [ENTRY_W-1:0]   entry_ff, entry_in;
   logic [TIMER_W-1:0]   since_ff, since_in;
   logic [TIMER_W-1:0]   exit_ff, exit_in;
   logic [BLINK_W-1:0]   blink_cnt_ff, blink_cnt_in;
   logic                 phase_ff, phase_in;
   logic                 announce_ff, announce_in;

   // code entry results
   logic [TIMER_W-1:0]   tick_cnt;
   logic [ENTRY_W-1:0]   ce_entry;
   logic [TIMER_W-1:0]   ce_since;
   logic [1:0]           ce_ev;
   logic                 want_bit;
   logic [ENTRY_W:0]     entry_next;

   logic [BLINK_W:0]     blink_next;
   logic                 light_hit;
   logic [1:0]           code_ev;
   logic [2:0]           alarm_ev;
   logic                 green;

   // Code entry step, shared by idle and triggered
   always_comb begin
      tick_cnt   = (since_ff != {TIMER_W{1'b1}}) ? since_ff + 16'd1 : since_ff;
      want_bit   = (entry_ff[2] == 1'b0) ? cfg.code_pattern[entry_ff[1:0]] : 1'b0;
      entry_next = {1'b0, entry_ff} + 4'd1;
      ce_entry   = entry_ff;
      ce_since   = tick_cnt;
      ce_ev      = CODE_EV_NONE;
      if (tick_cnt >= cfg.entry_timeout) begin
         // pause too long: restart, press ignored
         ce_entry = '0;
         ce_since = '0;
      end else if ((item.press_one || item.press_two) &&
                   (tick_cnt > {8'd0, cfg.debounce_ticks})) begin
         ce_since = '0;
         if (item.press_one != want_bit) begin
            ce_entry = '0;
            ce_ev    = CODE_EV_WRONG;
         end else if (entry_next >= CODE_LEN_W) begin
            ce_entry = '0;
            ce_ev    = CODE_EV_RIGHT;
         end else begin
            ce_entry = entry_next[ENTRY_W-1:0];
         end
      end
   end

   // Mode logic and next state
   always_comb begin
      mode_in      = mode_ff;
      entry_in     = entry_ff;
      since_in     = since_ff;
      exit_in      = exit_ff;
      blink_cnt_in = blink_cnt_ff;
      phase_in     = phase_ff;
      announce_in  = announce_ff;
      code_ev      = CODE_EV_NONE;
      alarm_ev     = ALARM_EV_NONE;
      blink_next   = {1'b0, blink_cnt_ff} + 10'd1;
      light_hit    = item.light_level >= cfg.light_threshold;
      case (mode_ff)
         MODE_ARMED: begin
            if (exit_ff < cfg.exit_delay) begin
               // exit delay, sensors ignored
               exit_in = exit_ff + 16'd1;
               if (blink_next >= BLINK_HALF_W) begin
                  blink_cnt_in = '0;
                  phase_in     = ~phase_ff;
               end else begin
                  blink_cnt_in = blink_next[BLINK_W-1:0];
               end
            end else if (announce_ff) begin
               alarm_ev    = ALARM_EV_ARMED;
               announce_in = 1'b0;
            end else if (light_hit || item.motion_seen) begin
               alarm_ev    = light_hit ? ALARM_EV_LIGHT : ALARM_EV_MOTION;
               mode_in     = MODE_TRIG;
               entry_in    = '0;
               since_in    = '0;
               announce_in = 1'b0;
            end
         end
         MODE_TRIG: begin
            code_ev  = ce_ev;
            entry_in = ce_entry;
            since_in = ce_since;
            if (ce_ev == CODE_EV_RIGHT) begin
               mode_in     = MODE_IDLE;
               announce_in = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (announce_ff) begin
               alarm_ev    = ALARM_EV_UNARMED;
               announce_in = 1'b0;
            end
            code_ev  = ce_ev;
            entry_in = ce_entry;
            since_in = ce_since;
            if (ce_ev == CODE_EV_RIGHT) begin
               mode_in      = MODE_ARMED;
               exit_in      = '0;
               blink_cnt_in = '0;
               phase_in     = 1'b1;
               announce_in  = 1'b1;
            end
         end
      endcase

      // lamps from the state after this tick
      green = 1'b0;
      if (mode_in == MODE_ARMED) begin
         green = (exit_in < cfg.exit_delay) ? phase_in : 1'b1;
      end

      result.panel_mode    = mode_in;
      result.code_event    = code_ev;
      result.alarm_event   = alarm_ev;
      result.code_progress = entry_in;
      result.yellow_lamp   = (mode_in == MODE_IDLE);
      result.green_lamp    = green;
      result.red_lamp      = (mode_in == MODE_TRIG);
      result.buzzer_on     = (mode_in == MODE_TRIG);
   end

   // Panel state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         entry_ff     <= '0;
         since_ff     <= '0;
         exit_ff      <= '0;
         blink_cnt_ff <= '0;
         phase_ff     <= 1'b1;
         announce_ff  <= 1'b1;
      end else if (step) begin
         mode_ff      <= mode_in;
         entry_ff     <= entry_in;
         since_ff     <= since_in;
         exit_ff      <= exit_in;
         blink_cnt_ff <= blink_cnt_in;
         phase_ff     <= phase_in;
         announce_ff  <= announce_in;
      end
   end
endmodule

// File: src/alarm_panel_controller_top.sv
`timescale 1ns / 1ps

// A word accepted on the request channel passes through the input register, then the
// result register, before it appears on the result channel.
// Throughput: one word per cycle while the result channel is ready.
// Reset: synchronous, active high; panel idle, registers at their defaults, both
// pipeline stages empty, first result reports unarmed.
module alarm_panel_controller_top #(
   parameter int CODE_LENGTH = apc_pkg::CODE_LENGTH_DEF,
   parameter int BLINK_HALF  = apc_pkg::BLINK_HALF_DEF
) (
   input  logic     clock,
   input  logic     reset,
   apc_req_if.sink  req_chan,
   apc_rsp_if.source rsp_chan,
   apc_csr_if.sink  csr_chan
);
   import apc_pkg::*;

   cfg_type      cfg;
   req_item_type inp_ff;
   logic         inp_valid_ff;
   rsp_item_type out_ff;
   logic         out_valid_ff;
   rsp_item_type result;
   logic         advance;

   // Stage moves when the result register is free or being emptied
   assign advance        = inp_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !inp_valid_ff || advance;

   apc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   apc_engine #(
      .CODE_LENGTH (CODE_LENGTH),
      .BLINK_HALF  (BLINK_HALF)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (inp_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         inp_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         inp_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         inp_ff.press_one   <= req_chan.press_one;
         inp_ff.press_two   <= req_chan.press_two;
         inp_ff.light_level <= req_chan.light_level;
         inp_ff.motion_seen <= req_chan.motion_seen;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.panel_mode    = out_ff.panel_mode;
   assign rsp_chan.code_event    = out_ff.code_event;
   assign rsp_chan.alarm_event   = out_ff.alarm_event;
   assign rsp_chan.code_progress = out_ff.code_progress;
   assign rsp_chan.yellow_lamp   = out_ff.yellow_lamp;
   assign rsp_chan.green_lamp    = out_ff.green_lamp;
   assign rsp_chan.red_lamp      = out_ff.red_lamp;
   assign rsp_chan.buzzer_on     = out_ff.buzzer_on;
endmodule
